FILE: rtl/srupg_pkg.sv
// ----------------------------------------------------------------------------
// srupg_pkg
// Shared types, mixing constants and polynomial coefficients of the phasor
// generator.
// ----------------------------------------------------------------------------
package srupg_pkg;

    // Valid and last mark that travel down the pipeline beside the data.
    typedef struct packed {
        logic valid;
        logic last;
    } tag_t;

    localparam logic [63:0] GOLDEN_STEP = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL_A   = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_B   = 64'h94D049BB133111EB;

    localparam int          FRAC_W   = 30;
    localparam int          COEF_W   = 31;
    localparam int          HORNER_N = 4;
    localparam logic [14:0] ONE_Q14  = 15'd16384;
    localparam logic [30:0] ONE_Q30  = 31'd1073741824;

    // Horner coefficients in Q30, innermost first.
    localparam logic [30:0] SIN_TOP = 31'd172272;
    localparam logic [30:0] COS_TOP = 31'd27060;
    localparam logic [30:0] SIN_COEF [HORNER_N] =
        '{31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713};
    localparam logic [30:0] COS_COEF [HORNER_N] =
        '{31'd987048, 31'd22401992, 31'd272375560, 31'd1324675879};

    // Q30 product, truncated. Callers keep the result below 2^31.
    function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
        logic [61:0] p;
        p = 62'(a) * 62'(b);
        return p[60:30];
    endfunction

    // Round a Q30 magnitude half up to Q14 and clamp at one.
    function automatic logic [14:0] round_q14(input logic [30:0] v);
        logic [15:0] r;
        r = 16'((32'(v) + 32'd32768) >> 16);
        if (r > 16'(ONE_Q14))
        begin
            r = 16'(ONE_Q14);
        end
        return r[14:0];
    endfunction

endpackage

FILE: rtl/srupg_mixer.sv
// ----------------------------------------------------------------------------
// srupg_mixer
// Four-stage SplitMix64 output mix: each 64-bit multiply keeps only its low
// half and is split into 32x32 partial products summed one stage later.
// ----------------------------------------------------------------------------
module srupg_mixer
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               enable,
    input  srupg_pkg::tag_t    tag,
    input  logic [63:0]        state,
    output srupg_pkg::tag_t    mixed_tag,
    output logic [31:0]        phase
);

    srupg_pkg::tag_t tag_reg [4];
    logic [63:0] pa_ll_reg;
    logic [31:0] pa_lh_reg;
    logic [31:0] pa_hl_reg;
    logic [63:0] y_reg;
    logic [63:0] pb_ll_reg;
    logic [31:0] pb_lh_reg;
    logic [31:0] pb_hl_reg;
    logic [63:0] w_reg;
    logic [63:0] xa;
    logic [63:0] xb;
    logic [63:0] u;
    logic [63:0] pa_ll_next;
    logic [63:0] pb_ll_next;
    logic [63:0] pa_lh_full;
    logic [63:0] pa_hl_full;
    logic [63:0] pb_lh_full;
    logic [63:0] pb_hl_full;

    always_comb
    begin
        xa = state ^ (state >> 30);
        xb = y_reg ^ (y_reg >> 27);
        pa_ll_next = 64'(xa[31:0]) * 64'(srupg_pkg::MIX_MUL_A[31:0]);
        pa_lh_full = 64'(xa[31:0]) * 64'(srupg_pkg::MIX_MUL_A[63:32]);
        pa_hl_full = 64'(xa[63:32]) * 64'(srupg_pkg::MIX_MUL_A[31:0]);
        pb_ll_next = 64'(xb[31:0]) * 64'(srupg_pkg::MIX_MUL_B[31:0]);
        pb_lh_full = 64'(xb[31:0]) * 64'(srupg_pkg::MIX_MUL_B[63:32]);
        pb_hl_full = 64'(xb[63:32]) * 64'(srupg_pkg::MIX_MUL_B[31:0]);
        u = w_reg ^ (w_reg >> 31);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else if (enable)
        begin
            tag_reg[0] <= tag;
            for (int i = 1; i < 4; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            pa_ll_reg <= pa_ll_next;
            pa_lh_reg <= pa_lh_full[31:0];
            pa_hl_reg <= pa_hl_full[31:0];
            y_reg     <= pa_ll_reg + {pa_lh_reg + pa_hl_reg, 32'b0};
            pb_ll_reg <= pb_ll_next;
            pb_lh_reg <= pb_lh_full[31:0];
            pb_hl_reg <= pb_hl_full[31:0];
            w_reg     <= pb_ll_reg + {pb_lh_reg + pb_hl_reg, 32'b0};
        end
    end

    assign mixed_tag = tag_reg[3];
    assign phase     = u[63:32];

endmodule

FILE: rtl/srupg_sincos.sv
// ----------------------------------------------------------------------------
// srupg_sincos
// Seven-stage quarter-turn sine and cosine: square, four Horner steps per
// lane, final product, then rounding and quadrant rotation into the output
// register.
// ----------------------------------------------------------------------------
module srupg_sincos
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               enable,
    input  logic               exact_zero,
    input  srupg_pkg::tag_t    tag,
    input  logic [31:0]        phase,
    output srupg_pkg::tag_t    out_tag,
    output logic signed [15:0] cos_out,
    output logic signed [15:0] sin_out
);

    localparam int LAST_H = srupg_pkg::HORNER_N + 1;

    srupg_pkg::tag_t tag_reg [1:LAST_H+2];
    logic [29:0] t_reg  [1:LAST_H];
    logic [29:0] z_reg  [1:LAST_H];
    logic [1:0]  q_reg  [1:LAST_H+1];
    logic        zf_reg [1:LAST_H+1];
    logic [30:0] ps_reg [2:LAST_H];
    logic [30:0] pc_reg [2:LAST_H];
    logic [30:0] sv_reg;
    logic [30:0] cz_reg;
    logic signed [15:0] cos_reg;
    logic signed [15:0] sin_reg;

    logic [30:0] z_next;
    logic [30:0] ps_next [2:LAST_H];
    logic [30:0] pc_next [2:LAST_H];
    logic [30:0] ps_in;
    logic [30:0] pc_in;
    logic [30:0] cq;
    logic signed [15:0] c;
    logic signed [15:0] s;
    logic signed [15:0] cos_next;
    logic signed [15:0] sin_next;

    always_comb
    begin
        z_next = srupg_pkg::mul_q30({1'b0, phase[29:0]}, {1'b0, phase[29:0]});
        for (int k = 2; k <= LAST_H; k++)
        begin
            ps_in = (k == 2) ? srupg_pkg::SIN_TOP : ps_reg[k == 2 ? 2 : k-1];
            pc_in = (k == 2) ? srupg_pkg::COS_TOP : pc_reg[k == 2 ? 2 : k-1];
            ps_next[k] = srupg_pkg::SIN_COEF[k-2]
                       - srupg_pkg::mul_q30({1'b0, z_reg[k-1]}, ps_in);
            pc_next[k] = srupg_pkg::COS_COEF[k-2]
                       - srupg_pkg::mul_q30({1'b0, z_reg[k-1]}, pc_in);
        end

        cq = (cz_reg >= srupg_pkg::ONE_Q30) ? 31'd0 : (srupg_pkg::ONE_Q30 - cz_reg);
        c  = $signed({1'b0, srupg_pkg::round_q14(cq)});
        s  = $signed({1'b0, srupg_pkg::round_q14(sv_reg)});
        // In quarter-turn mode a zero fraction is forced to an exact axis point.
        if (zf_reg[LAST_H+1])
        begin
            c = $signed({1'b0, srupg_pkg::ONE_Q14});
            s = '0;
        end
        case (q_reg[LAST_H+1])
            2'd0:
            begin
                cos_next = c;
                sin_next = s;
            end
            2'd1:
            begin
                cos_next = -s;
                sin_next = c;
            end
            2'd2:
            begin
                cos_next = -c;
                sin_next = -s;
            end
            default:
            begin
                cos_next = s;
                sin_next = -c;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= LAST_H+2; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else if (enable)
        begin
            tag_reg[1] <= tag;
            for (int i = 2; i <= LAST_H+2; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            t_reg[1]  <= phase[29:0];
            z_reg[1]  <= z_next[29:0];
            q_reg[1]  <= phase[31:30];
            zf_reg[1] <= exact_zero && (phase[29:0] == '0);
            for (int k = 2; k <= LAST_H; k++)
            begin
                t_reg[k]  <= t_reg[k-1];
                z_reg[k]  <= z_reg[k-1];
                ps_reg[k] <= ps_next[k];
                pc_reg[k] <= pc_next[k];
            end
            for (int k = 2; k <= LAST_H+1; k++)
            begin
                q_reg[k]  <= q_reg[k-1];
                zf_reg[k] <= zf_reg[k-1];
            end
            sv_reg  <= srupg_pkg::mul_q30({1'b0, t_reg[LAST_H]}, ps_reg[LAST_H]);
            cz_reg  <= srupg_pkg::mul_q30({1'b0, z_reg[LAST_H]}, pc_reg[LAST_H]);
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign out_tag = tag_reg[LAST_H+2];
    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

FILE: rtl/seeded_random_unit_phasor_generator_core.sv
// ----------------------------------------------------------------------------
// seeded_random_unit_phasor_generator_core
// Loads a seed and count per request and streams count random unit phasors
// from a SplitMix64 mixer and a fixed-point sine-cosine pipeline.
// ----------------------------------------------------------------------------
//  channel   signals                                       role
//  item      item_valid, item_stall, seed, count           request in
//  phasor    phasor_valid, phasor_stall, real_part,        result out
//            imag_part, last
//  cfg       cfg_valid, cfg_ready, angle_mode              register write
//
//  A request of count n (clamped to MAX_COUNT) occupies the issue counter for
//  n draws, one draw per cycle while the phasor side does not stall;
//  item_stall is high until the last draw is issued. After its request is
//  accepted, the first phasor passes the issue register, four mixer stages
//  and seven sine-cosine stages ending in the output register. A stall on the
//  phasor side while a phasor is valid freezes the whole pipeline and the issue
//  counter together. Reset clears the counter and all valid bits; angle_mode resets to 0.
// ----------------------------------------------------------------------------
module seeded_random_unit_phasor_generator_core
#(
    parameter int MAX_COUNT = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [63:0]        seed,
    input  logic [6:0]         count,
    output logic               phasor_valid,
    input  logic               phasor_stall,
    output logic signed [15:0] real_part,
    output logic signed [15:0] imag_part,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               angle_mode
);

    localparam int CNT_W = $clog2(MAX_COUNT + 1);

    logic [63:0]       state_reg;
    logic [CNT_W-1:0]  remaining_reg;
    logic              angle_mode_reg;
    logic [63:0]       draw_reg;
    srupg_pkg::tag_t   draw_tag_reg;
    srupg_pkg::tag_t   draw_tag_next;
    srupg_pkg::tag_t   mixed_tag;
    srupg_pkg::tag_t   out_tag;
    logic [31:0]       phase;
    logic [63:0]       state_step;
    logic [CNT_W-1:0]  count_clamped;
    logic              advance;
    logic              item_take;

    assign advance    = !(out_tag.valid && phasor_stall);
    assign item_stall = (remaining_reg != '0);
    assign item_take  = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;
    assign state_step = state_reg + srupg_pkg::GOLDEN_STEP;

    always_comb
    begin
        if (count > 7'(MAX_COUNT))
        begin
            count_clamped = CNT_W'(MAX_COUNT);
        end
        else
        begin
            count_clamped = CNT_W'(count);
        end
        draw_tag_next.valid = (remaining_reg != '0);
        draw_tag_next.last  = (remaining_reg == CNT_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg  <= '0;
            angle_mode_reg <= 1'b0;
            draw_tag_reg   <= '0;
            state_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                angle_mode_reg <= angle_mode;
            end
            if (item_take)
            begin
                state_reg     <= seed;
                remaining_reg <= count_clamped;
            end
            else if (advance && remaining_reg != '0)
            begin
                state_reg     <= state_step;
                remaining_reg <= remaining_reg - CNT_W'(1);
            end
            if (advance)
            begin
                draw_tag_reg <= draw_tag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            draw_reg <= state_step;
        end
    end

    srupg_mixer u_mixer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (advance),
        .tag       (draw_tag_reg),
        .state     (draw_reg),
        .mixed_tag (mixed_tag),
        .phase     (phase)
    );

    srupg_sincos u_sincos
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (advance),
        .exact_zero (angle_mode_reg),
        .tag        (mixed_tag),
        .phase      (phase),
        .out_tag    (out_tag),
        .cos_out    (real_part),
        .sin_out    (imag_part)
    );

    assign phasor_valid = out_tag.valid;
    assign last         = out_tag.last;

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && count != 7'd0) |=> item_stall)
        else $error("issue counter idle after a nonzero request");

    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (remaining_reg != '0) |=> (remaining_reg == $past(remaining_reg))
            || (remaining_reg == $past(remaining_reg) - CNT_W'(1)))
        else $error("issue counter moved by more than one");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        phasor_valid |-> (real_part <= 16'sd16384 && real_part >= -16'sd16384
            && imag_part <= 16'sd16384 && imag_part >= -16'sd16384))
        else $error("phasor component out of range");

    a_draw_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (phasor_valid && phasor_stall && remaining_reg != '0)
            |=> $stable(state_reg))
        else $error("generator advanced during a stall");

endmodule

FILE: sim/seeded_random_unit_phasor_generator_core_checker.sv
// ----------------------------------------------------------------------------
// Phasor stream checker
// Watches the request, phasor and register channels of the phasor generator.
// For every accepted request it works out the expected phasor stream and
// compares each accepted phasor with it, field by field.
// ----------------------------------------------------------------------------
module seeded_random_unit_phasor_generator_core_checker
#(
    parameter int MAX_COUNT = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_stall,
    input  logic [63:0]        seed,
    input  logic [6:0]         count,
    input  logic               phasor_valid,
    input  logic               phasor_stall,
    input  logic signed [15:0] real_part,
    input  logic signed [15:0] imag_part,
    input  logic               last,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic               angle_mode,
    output int                 fail_count,
    output int                 pending_phasors,
    output int                 phasors_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic               fin;
    } phasor_t;

    localparam logic [63:0] STEP  = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MUL_A = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MUL_B = 64'h94D049BB133111EB;

    phasor_t     expected_phasors[$];
    logic        mode_shadow;
    logic [63:0] mixer_state;

    // Truncated Q30 product; operands stay well below 2^32.
    function automatic logic [63:0] q30_product(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        p = a * b;
        return p >> 30;
    endfunction

    function automatic logic signed [15:0] to_q14(input logic [63:0] v);
        logic [63:0] r;
        r = (v + 64'd32768) >> 16;
        if (r > 64'd16384)
        begin
            r = 64'd16384;
        end
        return 16'(r);
    endfunction

    function automatic phasor_t phasor_of(input logic [63:0] draw);
        logic [31:0]        phase;
        logic [63:0]        t;
        logic [63:0]        z;
        logic [63:0]        p;
        logic [63:0]        cz;
        logic signed [15:0] c;
        logic signed [15:0] s;
        phasor_t            ph;
        phase = draw[63:32];
        t = {34'd0, phase[29:0]};
        z = q30_product(t, t);
        p = 64'd5026995 - q30_product(z, 64'd172272);
        p = 64'd85569306 - q30_product(z, p);
        p = 64'd693598668 - q30_product(z, p);
        p = 64'd1686629713 - q30_product(z, p);
        s = to_q14(q30_product(t, p));
        p = 64'd987048 - q30_product(z, 64'd27060);
        p = 64'd22401992 - q30_product(z, p);
        p = 64'd272375560 - q30_product(z, p);
        p = 64'd1324675879 - q30_product(z, p);
        cz = q30_product(z, p);
        c = to_q14((cz >= 64'd1073741824) ? 64'd0 : 64'd1073741824 - cz);
        case (phase[31:30])
            2'd0: begin ph.re = c;  ph.im = s;  end
            2'd1: begin ph.re = -s; ph.im = c;  end
            2'd2: begin ph.re = -c; ph.im = -s; end
            default: begin ph.re = s; ph.im = -c; end
        endcase
        ph.fin = 1'b0;
        return ph;
    endfunction

    task automatic predict_run(input logic [63:0] start, input logic [6:0] n_req);
        int          n;
        logic [63:0] z;
        phasor_t     ph;
        n = (n_req > MAX_COUNT) ? MAX_COUNT : int'(n_req);
        mixer_state = start;
        for (int k = 0; k < n; k++)
        begin
            mixer_state = mixer_state + STEP;
            z = mixer_state;
            z = (z ^ (z >> 30)) * MUL_A;
            z = (z ^ (z >> 27)) * MUL_B;
            z = z ^ (z >> 31);
            ph = phasor_of(z);
            ph.fin = (k == n - 1);
            expected_phasors.push_back(ph);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] phasor %0d: %s", $realtime, phasors_seen, what);
        fail_count++;
    endtask

    // The pending count is settled at the clock edge, so the top can read it
    // safely at the following falling edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_shadow <= 1'b0;
            mixer_state = '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mode_shadow <= angle_mode;
            end
            if (item_valid && !item_stall)
            begin
                predict_run(seed, count);
            end
            if (phasor_valid && !phasor_stall)
            begin
                if (expected_phasors.size() == 0)
                begin
                    report_mismatch("unexpected phasor");
                end
                else
                begin
                    phasor_t e;
                    e = expected_phasors.pop_front();
                    if (real_part !== e.re)
                        report_mismatch($sformatf("real_part %0d expected %0d", real_part, e.re));
                    if (imag_part !== e.im)
                        report_mismatch($sformatf("imag_part %0d expected %0d", imag_part, e.im));
                    if (last !== e.fin)
                        report_mismatch($sformatf("last %0b expected %0b", last, e.fin));
                end
                phasors_seen++;
            end
            pending_phasors = expected_phasors.size();
        end
    end

    initial
    begin
        fail_count = 0;
        pending_phasors = 0;
        phasors_seen = 0;
    end
endmodule

FILE: sim/seeded_random_unit_phasor_generator_core_tb.sv
// ----------------------------------------------------------------------------
// Phasor generator testbench
// Drives seed and count requests and register writes into the generator
// under several idle and stall patterns; a checker beside the block
// predicts and compares every phasor.
// ----------------------------------------------------------------------------
module seeded_random_unit_phasor_generator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    logic [63:0]        seed;
    logic [6:0]         count;
    logic               phasor_valid;
    logic               phasor_stall = 1'b0;
    logic signed [15:0] real_part;
    logic signed [15:0] imag_part;
    logic               last;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               angle_mode;
    int                 fail_count;
    int                 pending_phasors;
    int                 phasors_seen;
    int                 cycle_count = 0;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 hold_off_cycles = 0;
    int                 hold_off_asked = 0;
    int                 hold_off_seen = 0;
    int                 requests_sent;

    seeded_random_unit_phasor_generator_core DUT (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .seed(seed), .count(count),
        .phasor_valid(phasor_valid), .phasor_stall(phasor_stall),
        .real_part(real_part), .imag_part(imag_part), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .angle_mode(angle_mode)
    );

    seeded_random_unit_phasor_generator_core_checker CHECK (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .seed(seed), .count(count),
        .phasor_valid(phasor_valid), .phasor_stall(phasor_stall),
        .real_part(real_part), .imag_part(imag_part), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .angle_mode(angle_mode),
        .fail_count(fail_count), .pending_phasors(pending_phasors),
        .phasors_seen(phasors_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("seeded_random_unit_phasor_generator_core: mismatch");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_off_asked != hold_off_seen)
        begin
            hold_off_seen <= hold_off_asked;
            hold_off_cycles <= 300;
            phasor_stall <= 1'b1;
        end
        else if (hold_off_cycles > 0)
        begin
            phasor_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
        begin
            phasor_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Valid stays high after acceptance only while the next request follows
    // at once; idle and drain phases drop it.
    task automatic send_request(input logic [63:0] s, input logic [6:0] n);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        seed <= s;
        count <= n;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        requests_sent++;
    endtask

    task automatic drain_all();
        item_valid <= 1'b0;
        @(negedge clk);
        while (pending_phasors != 0)
        begin
            @(negedge clk);
        end
        // Zero-count requests produce nothing; let the pipeline settle.
        repeat (20) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        cfg_valid <= 1'b1;
        angle_mode <= m;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [6:0] random_count();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 7'd0;
        else if (r < 10)
            return 7'($urandom_range(127, 65));
        else if (r < 15)
            return 7'd64;
        return 7'($urandom_range(8, 1));
    endfunction

    function automatic logic [63:0] random_seed();
        return {$urandom(), $urandom()};
    endfunction

    // The generator step; its negation is a seed whose first step wraps the state to zero.
    function automatic logic [63:0] STEP_SEED();
        return 64'h9E3779B97F4A7C15;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        seed = '0;
        count = '0;
        cfg_valid = 1'b0;
        angle_mode = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        requests_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme seeds and counts, including zero and saturating counts.
        send_request(64'd0, 7'd1);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 7'd3);
        send_request(64'd0, 7'd0);
        send_request(64'h8000_0000_0000_0000, 7'd64);
        send_request(64'h0123_4567_89AB_CDEF, 7'd127);
        send_request(64'h5555_5555_5555_5555, 7'd65);
        send_request(64'hAAAA_AAAA_AAAA_AAAA, 7'd2);
        send_request(-STEP_SEED(), 7'd4);
        drain_all();
        write_mode(1'b1);
        send_request(64'd0, 7'd8);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 7'd64);
        send_request(64'd1, 7'd0);
        send_request(64'hDEAD_BEEF_0000_0001, 7'd100);
        drain_all();

        for (int phase = 0; phase < 4; phase++)
        begin
            write_mode(phase[0]);
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            for (int i = 0; i < 115; i++)
            begin
                if (phase == 0 && i == 40)
                begin
                    hold_off_asked <= hold_off_asked + 1;
                end
                if (i == 60)
                begin
                    // Let the block run dry before resuming.
                    item_valid <= 1'b0;
                    @(negedge clk);
                    while (pending_phasors != 0)
                    begin
                        @(negedge clk);
                    end
                end
                send_request(random_seed(), random_count());
            end
            drain_all();
        end
        write_mode(1'b0);
        recv_stall_pct = 0;
        drain_all();

        $display("Sent %0d seed requests over four idle/stall patterns in both angle modes;",
                 requests_sent);
        $display("checked %0d phasors against the predicted stream.", phasors_seen);
        if (fail_count == 0)
        begin
            $display("seeded_random_unit_phasor_generator_core: match");
        end
        else
        begin
            $display("seeded_random_unit_phasor_generator_core: mismatch");
        end
        $finish;
    end
endmodule
